/* hw/rtl/rmr_pkg.sv */
// shared types and constants for the row marginal reducer
`default_nettype none

package rmr_pkg;

    // fixed field widths
    localparam int VALUE_W    = 24;
    localparam int PROD_W     = 2 * VALUE_W;
    localparam int MODE_W     = 2;
    localparam int ROW_LEN_W  = 11;

    // register file
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 1;
    localparam logic [REG_IDX_W-1:0] REG_MODE       = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROW_LENGTH = 1'd1;
    localparam logic [ROW_LEN_W-1:0] ROW_LEN_RESET  = 11'd1024;

    // reduction modes, the unused code behaves as the plain mean
    typedef enum logic [MODE_W-1:0] {
        MODE_MEAN  = 2'd0,
        MODE_WMEAN = 2'd1,
        MODE_PEAK  = 2'd2
    } mode_t;

    // controller states
    typedef enum logic [2:0] {
        ST_ACCUM  = 3'd0,
        ST_FLUSH  = 3'd1,
        ST_START  = 3'd2,
        ST_DIVIDE = 3'd3,
        ST_WRITE  = 3'd4
    } state_t;

    // input beat
    typedef struct packed {
        logic signed [VALUE_W-1:0] sample_value;
        logic        [VALUE_W-1:0] sample_weight;
    } sample_beat_t;

    // output beat
    typedef struct packed {
        logic signed [VALUE_W-1:0] row_result;
        logic                      zero_weight;
    } result_beat_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic snap;
        logic div_start;
        logic load_out;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last_item;
        logic need_div;
        logic div_done;
    } ctrl_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/row_marginal_reducer.sv */
// top level of the row marginal reducer
`default_nettype none

// Reduces each row of a Q12.12 time-frequency matrix to one value: plain mean
// (mode 0, also mode 3), energy-weighted mean sum(v*w)/sum(w) (mode 1, with
// zero_weight set and a 0 result when the weights sum to zero), or the value
// at the first strictly largest positive weight (mode 2). Registers over APB:
// mode at 0x0, row_length at 0x4 (0 acts as 1, values above MAX_ROW clip to
// MAX_ROW). Within a row one sample beat is taken per cycle. After the last
// sample of a row the input stalls while the row result is formed: through
// the FLUSH, START and WRITE states in mode 2 or on zero weight, and also
// through the DIVIDE state in the mean modes, where the restoring divider
// produces one quotient bit per cycle. The result sits in an output register,
// so the next row streams in while it waits to be taken; a further row end
// holds until that register is free.
module row_marginal_reducer
    import rmr_pkg::*;
#(
    parameter int MAX_ROW = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  sample_valid,
    output logic                  sample_ready,
    input  sample_beat_t          sample_beat,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_beat_t          result_beat
);

    logic [MODE_W-1:0]    mode;
    logic [ROW_LEN_W-1:0] row_length;
    ctrl_cmd_t            cmd;
    ctrl_sts_t            sts;

    assign pready = 1'b1;

    rmr_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .mode       (mode),
        .row_length (row_length)
    );

    rmr_dp #(
        .MAX_ROW (MAX_ROW)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .mode        (mode),
        .row_length  (row_length),
        .sample_beat (sample_beat),
        .cmd         (cmd),
        .sts         (sts),
        .result_beat (result_beat)
    );

    rmr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .sts          (sts),
        .cmd          (cmd)
    );

endmodule

`default_nettype wire

/* hw/rtl/rmr_regs.sv */
// configuration registers behind the apb port
`default_nettype none

module rmr_regs
    import rmr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic [MODE_W-1:0]     mode,
    output logic [ROW_LEN_W-1:0]  row_length
);

    logic [MODE_W-1:0]    mode_reg, mode_next;
    logic [ROW_LEN_W-1:0] row_length_reg, row_length_next;
    logic [REG_IDX_W-1:0] reg_idx;

    assign reg_idx = paddr[APB_ADDR_W-1:2];

    // register write decode
    always_comb
    begin
        mode_next       = mode_reg;
        row_length_next = row_length_reg;
        if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                REG_MODE:       mode_next       = pwdata[MODE_W-1:0];
                REG_ROW_LENGTH: row_length_next = pwdata[ROW_LEN_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_MEAN;
            row_length_reg <= ROW_LEN_RESET;
        end
        else
        begin
            mode_reg       <= mode_next;
            row_length_reg <= row_length_next;
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_idx)
            REG_MODE:       prdata = APB_DATA_W'(mode_reg);
            REG_ROW_LENGTH: prdata = APB_DATA_W'(row_length_reg);
            default:        prdata = '0;
        endcase
    end

    assign mode       = mode_reg;
    assign row_length = row_length_reg;

endmodule

`default_nettype wire

/* hw/rtl/rmr_div.sv */
// restoring divider, one quotient bit per cycle
`default_nettype none

module rmr_div #(
    parameter int DVD_W = 58,
    parameter int DVS_W = 34
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DVS_W:0]    shifted;
    logic [DVS_W:0]    diff;
    logic              ge;

    // trial subtract of the shifted remainder
    assign shifted = {rem_reg, quo_reg[DVD_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            step_next = STEP_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[DVD_W-2:0], ge};
            rem_next  = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // operands and partial results
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

/* hw/rtl/rmr_dp.sv */
// datapath: row accumulators, operand select, divider and output register
`default_nettype none

module rmr_dp
    import rmr_pkg::*;
#(
    parameter int MAX_ROW = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [MODE_W-1:0]    mode,
    input  logic [ROW_LEN_W-1:0] row_length,
    input  sample_beat_t         sample_beat,
    input  ctrl_cmd_t            cmd,
    output ctrl_sts_t            sts,
    output result_beat_t         result_beat
);

    localparam int LOG_W = $clog2(MAX_ROW);
    localparam int CNT_W = $clog2(MAX_ROW + 1);
    localparam int LEN_W = (CNT_W > ROW_LEN_W) ? CNT_W : ROW_LEN_W;
    localparam int PS_W  = PROD_W + LOG_W;
    localparam int WS_W  = VALUE_W + LOG_W;
    localparam int VS_W  = VALUE_W + LOG_W;

    logic signed [VALUE_W-1:0] v;
    logic        [VALUE_W-1:0] w;
    logic signed [PROD_W-1:0]  prod_next;

    logic signed [PROD_W-1:0]  prod_reg;
    logic                      prod_pend_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_inc;
    logic [PS_W-1:0]           product_sum_reg;
    logic [WS_W-1:0]           weight_sum_reg;
    logic [VS_W-1:0]           value_sum_reg;
    logic [VALUE_W-1:0]        best_weight_reg;
    logic [VALUE_W-1:0]        best_value_reg;
    logic [MODE_W-1:0]         mode_item_reg;

    logic [LEN_W-1:0]          eff_len;
    logic [PS_W-1:0]           dvd_u;
    logic [PS_W-1:0]           dvd_mag;
    logic                      dvd_neg;
    logic [WS_W-1:0]           dvs;
    logic                      wmean;
    logic                      zero_sum;

    logic                      neg_snap_reg;
    logic                      zw_snap_reg;
    logic                      peak_snap_reg;
    logic [VALUE_W-1:0]        peak_snap_value_reg;

    logic [PS_W-1:0]           quotient;
    logic [PS_W-1:0]           quo_signed;
    logic                      div_done;
    result_beat_t              result_reg, result_next;

    assign v         = sample_beat.sample_value;
    assign w         = sample_beat.sample_weight;
    assign prod_next = v * $signed({1'b0, w});
    assign count_inc = count_reg + 1'b1;

    // effective row length: zero acts as one, clipped to MAX_ROW
    always_comb
    begin
        eff_len = LEN_W'(row_length);
        if (row_length == '0)
            eff_len = LEN_W'(1);
        else if (LEN_W'(row_length) > LEN_W'(MAX_ROW))
            eff_len = LEN_W'(MAX_ROW);
    end

    // product register, added into the sum in the cycle after the beat
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            prod_reg <= prod_next;
    end

    // row accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_pend_reg   <= 1'b0;
            count_reg       <= '0;
            product_sum_reg <= '0;
            weight_sum_reg  <= '0;
            value_sum_reg   <= '0;
            best_weight_reg <= '0;
            best_value_reg  <= '0;
            mode_item_reg   <= MODE_MEAN;
        end
        else
        begin
            prod_pend_reg <= cmd.accept;
            if (cmd.snap)
            begin
                count_reg       <= '0;
                product_sum_reg <= '0;
                weight_sum_reg  <= '0;
                value_sum_reg   <= '0;
                best_weight_reg <= '0;
                best_value_reg  <= '0;
            end
            else
            begin
                if (prod_pend_reg)
                    product_sum_reg <= product_sum_reg
                        + {{(PS_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
                if (cmd.accept)
                begin
                    count_reg      <= count_inc;
                    weight_sum_reg <= weight_sum_reg + WS_W'(w);
                    value_sum_reg  <= value_sum_reg + {{(VS_W-VALUE_W){v[VALUE_W-1]}}, v};
                    mode_item_reg  <= mode;
                    if (w > best_weight_reg)
                    begin
                        best_weight_reg <= w;
                        best_value_reg  <= v;
                    end
                end
            end
        end
    end

    // divider operands for the finished row
    assign wmean    = (mode_item_reg == MODE_WMEAN);
    assign zero_sum = (weight_sum_reg == '0);

    always_comb
    begin
        case (mode_item_reg)
            MODE_WMEAN:
            begin
                dvd_u = product_sum_reg;
                dvs   = weight_sum_reg;
            end
            default:
            begin
                dvd_u = {{(PS_W-VS_W){value_sum_reg[VS_W-1]}}, value_sum_reg};
                dvs   = WS_W'(count_reg);
            end
        endcase
    end

    assign dvd_neg = dvd_u[PS_W-1];
    assign dvd_mag = dvd_neg ? ('0 - dvd_u) : dvd_u;

    // row snapshot taken as the accumulators clear
    always_ff @(posedge clk)
    begin
        if (cmd.snap)
        begin
            neg_snap_reg        <= dvd_neg;
            zw_snap_reg         <= wmean && zero_sum;
            peak_snap_reg       <= (mode_item_reg == MODE_PEAK);
            peak_snap_value_reg <= best_value_reg;
        end
    end

    rmr_div #(
        .DVD_W (PS_W),
        .DVS_W (WS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dvd_mag),
        .divisor  (dvs),
        .done     (div_done),
        .quotient (quotient)
    );

    assign quo_signed = neg_snap_reg ? ('0 - quotient) : quotient;

    // result beat
    always_comb
    begin
        result_next.zero_weight = zw_snap_reg;
        if (zw_snap_reg)
            result_next.row_result = '0;
        else if (peak_snap_reg)
            result_next.row_result = peak_snap_value_reg;
        else
            result_next.row_result = quo_signed[VALUE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
            result_reg <= result_next;
    end

    assign result_beat   = result_reg;
    assign sts.last_item = (LEN_W'(count_inc) >= eff_len);
    assign sts.need_div  = (mode_item_reg != MODE_PEAK) && !(wmean && zero_sum);
    assign sts.div_done  = div_done;

endmodule

`default_nettype wire

/* hw/rtl/rmr_ctrl.sv */
// controller: row sequencing and the handshakes of both channels
`default_nettype none

module rmr_ctrl
    import rmr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      sample_valid,
    output logic      sample_ready,
    output logic      result_valid,
    input  logic      result_ready,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    state_t state_reg, state_next;
    logic   result_valid_reg, result_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_ACCUM;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        sample_ready  = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            ST_ACCUM:
            begin
                sample_ready = 1'b1;
                cmd.accept   = sample_valid;
                if (sample_valid && sts.last_item)
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                state_next = ST_START;
            end
            ST_START:
            begin
                cmd.snap = 1'b1;
                if (sts.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVIDE;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_DIVIDE:
            begin
                if (sts.div_done)
                    state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    // output beat valid
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (cmd.load_out)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
    end

    assign result_valid = result_valid_reg;

endmodule

`default_nettype wire

/* hw/rtl/rmr_checker.sv */
// port-level checks for the row marginal reducer and their bind
`default_nettype none

module rmr_checker
    import rmr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pready,
    input  logic                  sample_ready,
    input  logic                  result_valid,
    input  logic                  result_ready,
    input  result_beat_t          result_beat
);

    // zero total weight always forces a zero result
    a_zero_weight_result: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_beat.zero_weight) |-> (result_beat.row_result == '0))
        else $error("zero_weight beat with nonzero row_result");

    // a new result only follows a cycle in which samples were held off
    a_result_after_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !$past(sample_ready))
        else $error("result beat appeared without a row end stall");

    // stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(result_beat)))
        else $error("stalled result beat changed or dropped");

    // config port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable) |-> pready)
        else $error("pready low during access");

endmodule

bind row_marginal_reducer rmr_checker u_checker (.*);

`default_nettype wire
